// ===== design/mpss_pkg.sv =====
// ============================================================================
// mpss_pkg
// Types and constants shared by the masked patch SAD search block.
// ============================================================================
package mpss_pkg;

   localparam int POS_W        = 8;
   localparam int COLOR_W      = 8;
   localparam int DEPTH_W      = 16;
   localparam int ID_W         = 20;
   localparam int SUM_W        = 24;
   localparam int COUNT_W      = 8;
   // depth difference plus up to three colour differences
   localparam int DIFF_W       = 17;
   localparam int MAX_CHANNELS = 3;
   // power of two: the queue pointers wrap by overflow
   localparam int QUEUE_DEPTH  = 4;

   localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_CAND = 1'b1
   } op_type;

   typedef struct packed {
      op_type                                op;
      logic                                  in_window;
      logic [POS_W-1:0]                      position;
      logic [MAX_CHANNELS-1:0][COLOR_W-1:0]  color;
      logic [DEPTH_W-1:0]                    depth;
      logic                                  pixel_valid;
      logic [ID_W-1:0]                       candidate_id;
      logic                                  last_in_patch;
      logic                                  last_candidate;
   } beat_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== design/masked_patch_sad_search.sv =====
// ============================================================================
// masked_patch_sad_search
// Masked sum-of-absolute-differences patch matcher for inpainting.
//
//   channel | direction | handshake            | beat carries
//   --------+-----------+----------------------+--------------------------------
//   req_    | in        | req_valid/req_ready  | load or candidate pixel
//   rsp_    | out       | rsp_valid/rsp_ready  | best id, best sum, valid count
//
// One beat per cycle is taken while the queue has room; the front
// register, a four-entry queue and a three-stage back (store read, difference
// sum, accumulate/compare) lie between req accept and rsp_valid.
// Reset is synchronous and clears control state; the patch store is not
// cleared. A result waiting on rsp_ready holds the back; the front keeps
// taking beats until the queue fills.
// ============================================================================
module masked_patch_sad_search #(
   parameter int PATCH_WINDOW   = 225,
   parameter int COLOR_CHANNELS = 3,
   parameter int INDEX_BITS     = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_position,
   input  logic [7:0]  req_color_red,
   input  logic [7:0]  req_color_green,
   input  logic [7:0]  req_color_blue,
   input  logic [15:0] req_depth_value,
   input  logic        req_pixel_valid,
   input  logic [19:0] req_candidate_id,
   input  logic        req_last_in_patch,
   input  logic        req_last_candidate,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_match_found,
   output logic [19:0] rsp_best_id,
   output logic [23:0] rsp_best_sum,
   output logic [7:0]  rsp_valid_count
);
   import mpss_pkg::*;

   queue_status_type q_status;
   beat_type         push_beat, head_beat;
   logic             push_valid, pop;

   mpss_front #(
      .PATCH_WINDOW (PATCH_WINDOW)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_position       (req_position),
      .req_color_red      (req_color_red),
      .req_color_green    (req_color_green),
      .req_color_blue     (req_color_blue),
      .req_depth_value    (req_depth_value),
      .req_pixel_valid    (req_pixel_valid),
      .req_candidate_id   (req_candidate_id),
      .req_last_in_patch  (req_last_in_patch),
      .req_last_candidate (req_last_candidate),
      .q_status           (q_status),
      .push_valid         (push_valid),
      .push_beat          (push_beat)
   );

   mpss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_beat  (push_beat),
      .pop        (pop),
      .head_beat  (head_beat),
      .q_status   (q_status)
   );

   mpss_back #(
      .PATCH_WINDOW   (PATCH_WINDOW),
      .COLOR_CHANNELS (COLOR_CHANNELS),
      .INDEX_BITS     (INDEX_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_beat       (head_beat),
      .q_status        (q_status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_match_found (rsp_match_found),
      .rsp_best_id     (rsp_best_id),
      .rsp_best_sum    (rsp_best_sum),
      .rsp_valid_count (rsp_valid_count)
   );

endmodule

// ===== design/mpss_front.sv =====
// ============================================================================
// mpss_front
// Accepts request beats, classifies them and hands them to the queue.
// Loads outside the patch window are dropped here.
// ============================================================================
module mpss_front #(
   parameter int PATCH_WINDOW = 225
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_cmd,
   input  logic [7:0]                req_position,
   input  logic [7:0]                req_color_red,
   input  logic [7:0]                req_color_green,
   input  logic [7:0]                req_color_blue,
   input  logic [15:0]               req_depth_value,
   input  logic                      req_pixel_valid,
   input  logic [19:0]               req_candidate_id,
   input  logic                      req_last_in_patch,
   input  logic                      req_last_candidate,
   input  mpss_pkg::queue_status_type q_status,
   output logic                      push_valid,
   output mpss_pkg::beat_type        push_beat
);
   import mpss_pkg::*;

   localparam logic [POS_W-1:0] WINDOW_LIMIT = POS_W'(PATCH_WINDOW);

   logic     front_valid_ff, front_valid_in;
   beat_type front_beat_ff, front_beat_in;
   logic     accept, keep, push;

   assign push       = front_valid_ff && !q_status.full;
   assign req_ready  = !front_valid_ff || push;
   assign accept     = req_valid && req_ready;
   assign push_valid = push;
   assign push_beat  = front_beat_ff;

   always_comb begin
      front_beat_in.op             = (req_cmd == OP_LOAD) ? OP_LOAD : OP_CAND;
      front_beat_in.in_window      = req_position < WINDOW_LIMIT;
      front_beat_in.position       = req_position;
      front_beat_in.color[0]       = req_color_red;
      front_beat_in.color[1]       = req_color_green;
      front_beat_in.color[2]       = req_color_blue;
      front_beat_in.depth          = req_depth_value;
      front_beat_in.pixel_valid    = req_pixel_valid;
      front_beat_in.candidate_id   = req_candidate_id;
      front_beat_in.last_in_patch  = req_last_in_patch;
      front_beat_in.last_candidate = req_last_candidate;
      // drop loads that fall outside the window
      keep = !(front_beat_in.op == OP_LOAD && !front_beat_in.in_window);
   end

   always_comb begin
      front_valid_in = front_valid_ff;
      if (accept) begin
         front_valid_in = keep;
      end else if (push) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_beat_ff <= front_beat_in;
      end
   end

endmodule

// ===== design/mpss_queue.sv =====
// ============================================================================
// mpss_queue
// Short FIFO of classified beats between the front and the back.
// ============================================================================
module mpss_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  mpss_pkg::beat_type         push_beat,
   input  logic                       pop,
   output mpss_pkg::beat_type         head_beat,
   output mpss_pkg::queue_status_type q_status
);
   import mpss_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   beat_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   assign q_status.full  = count_ff == (PTR_W+1)'(QUEUE_DEPTH);
   assign q_status.empty = count_ff == '0;
   assign head_beat      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_beat;
      end
   end

endmodule

// ===== design/mpss_back.sv =====
// ============================================================================
// mpss_back
// Executes queued beats: patch store access, difference sum, running SAD,
// best candidate tracking and the result register.
// ============================================================================
module mpss_back #(
   parameter int PATCH_WINDOW   = 225,
   parameter int COLOR_CHANNELS = 3,
   parameter int INDEX_BITS     = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mpss_pkg::beat_type         head_beat,
   input  mpss_pkg::queue_status_type q_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_match_found,
   output logic [19:0]                rsp_best_id,
   output logic [23:0]                rsp_best_sum,
   output logic [7:0]                 rsp_valid_count
);
   import mpss_pkg::*;

   localparam int ADDR_W  = $clog2(PATCH_WINDOW);
   localparam int NCH     = (COLOR_CHANNELS > MAX_CHANNELS) ? MAX_CHANNELS : COLOR_CHANNELS;
   localparam int IDX_W   = (INDEX_BITS < ID_W) ? INDEX_BITS : ID_W;
   localparam int COLOR_BITS = NCH * COLOR_W;
   localparam int ENTRY_W = COLOR_BITS + DEPTH_W + 1;

   function automatic logic [DEPTH_W-1:0] abs_diff(logic [DEPTH_W-1:0] a,
                                                    logic [DEPTH_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   // patch store: {valid, depth, colours}
   logic [ENTRY_W-1:0] store_mem [PATCH_WINDOW];
   logic [ENTRY_W-1:0] wr_entry;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]  head_addr;
   logic               advance, write_en, read_en;

   // stage 2: difference sum
   logic               s2_valid_ff;
   beat_type           s2_beat_ff;
   logic [DIFF_W-1:0]  diff_in;
   logic               hit_in;

   // stage 3: accumulate and compare
   logic               s3_valid_ff;
   beat_type           s3_beat_ff;
   logic               s3_hit_ff;
   logic [DIFF_W-1:0]  s3_diff_ff;

   logic [SUM_W-1:0]   running_ff, running_in;
   logic [SUM_W-1:0]   best_sum_ff, best_sum_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic               have_best_ff, have_best_in;
   logic [COUNT_W-1:0] valid_total_ff, valid_total_in;
   logic [SUM_W:0]     sum_full;
   logic [SUM_W-1:0]   sum_acc;
   logic               take;

   logic               emit;
   logic               res_found;
   logic [ID_W-1:0]    res_id;
   logic [SUM_W-1:0]   res_sum;

   logic               rsp_valid_ff;
   logic               rsp_found_ff;
   logic [ID_W-1:0]    rsp_id_ff;
   logic [SUM_W-1:0]   rsp_sum_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   // the whole back holds while a result waits in the output register
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign pop       = advance && !q_status.empty;
   assign head_addr = head_beat.position[ADDR_W-1:0];
   assign write_en  = pop && head_beat.op == OP_LOAD;
   assign read_en   = pop && head_beat.op == OP_CAND && head_beat.in_window;

   always_comb begin
      wr_entry = '0;
      for (int ch = 0; ch < NCH; ch++) begin
         wr_entry[ch*COLOR_W +: COLOR_W] = head_beat.color[ch];
      end
      wr_entry[COLOR_BITS +: DEPTH_W] = head_beat.depth;
      wr_entry[ENTRY_W-1]             = head_beat.pixel_valid;
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         store_mem[head_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (read_en) begin
         rd_data_ff <= store_mem[head_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= pop;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s2_beat_ff <= head_beat;
      end
      if (advance) begin
         s3_beat_ff <= s2_beat_ff;
         s3_hit_ff  <= hit_in;
         s3_diff_ff <= diff_in;
      end
   end

   always_comb begin
      hit_in  = s2_beat_ff.op == OP_CAND && s2_beat_ff.in_window && rd_data_ff[ENTRY_W-1];
      diff_in = DIFF_W'(abs_diff(s2_beat_ff.depth, rd_data_ff[COLOR_BITS +: DEPTH_W]));
      for (int ch = 0; ch < NCH; ch++) begin
         diff_in = diff_in + DIFF_W'(abs_diff(DEPTH_W'(s2_beat_ff.color[ch]),
                                              DEPTH_W'(rd_data_ff[ch*COLOR_W +: COLOR_W])));
      end
   end

   always_comb begin
      sum_full = {1'b0, running_ff} + (SUM_W+1)'(s3_diff_ff);
      if (s3_hit_ff) begin
         sum_acc = sum_full[SUM_W] ? SUM_MAX : sum_full[SUM_W-1:0];
      end else begin
         sum_acc = running_ff;
      end
      // strict compare keeps the earliest candidate on a tie
      take = s3_beat_ff.last_in_patch && valid_total_ff != '0 &&
             (!have_best_ff || sum_acc < best_sum_ff);

      running_in     = running_ff;
      best_sum_in    = best_sum_ff;
      best_idx_in    = best_idx_ff;
      have_best_in   = have_best_ff;
      valid_total_in = valid_total_ff;
      emit           = 1'b0;
      res_found      = 1'b0;
      res_id         = '0;
      res_sum        = '0;

      if (s3_valid_ff && advance) begin
         if (s3_beat_ff.op == OP_LOAD) begin
            if (s3_beat_ff.position == '0) begin
               running_in     = '0;
               best_sum_in    = '0;
               best_idx_in    = '0;
               have_best_in   = 1'b0;
               valid_total_in = COUNT_W'(s3_beat_ff.pixel_valid);
            end else if (s3_beat_ff.pixel_valid && valid_total_ff != COUNT_MAX) begin
               valid_total_in = valid_total_ff + 1'b1;
            end
         end else begin
            running_in = sum_acc;
            if (s3_beat_ff.last_in_patch) begin
               running_in = '0;
               if (take) begin
                  best_sum_in  = sum_acc;
                  best_idx_in  = s3_beat_ff.candidate_id[IDX_W-1:0];
                  have_best_in = 1'b1;
               end
               if (s3_beat_ff.last_candidate) begin
                  emit         = 1'b1;
                  res_found    = have_best_in;
                  res_id       = ID_W'(best_idx_in);
                  res_sum      = best_sum_in;
                  best_sum_in  = '0;
                  best_idx_in  = '0;
                  have_best_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff     <= '0;
         best_sum_ff    <= '0;
         best_idx_ff    <= '0;
         have_best_ff   <= 1'b0;
         valid_total_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         running_ff     <= running_in;
         best_sum_ff    <= best_sum_in;
         best_idx_ff    <= best_idx_in;
         have_best_ff   <= have_best_in;
         valid_total_ff <= valid_total_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_found_ff <= res_found;
         rsp_id_ff    <= res_id;
         rsp_sum_ff   <= res_sum;
         rsp_count_ff <= valid_total_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_found = rsp_found_ff;
   assign rsp_best_id     = rsp_id_ff;
   assign rsp_best_sum    = rsp_sum_ff;
   assign rsp_valid_count = rsp_count_ff;

endmodule

// ===== design/mpss_checker.sv =====
// ============================================================================
// mpss_checker
// Port-level checks on the result channel of masked_patch_sad_search.
// ============================================================================
module mpss_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_match_found,
   input logic [19:0] rsp_best_id,
   input logic [23:0] rsp_best_sum,
   input logic [7:0]  rsp_valid_count
);

   // no result survives a reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_match_found, rsp_best_id, rsp_best_sum, rsp_valid_count}))
      else $error("stalled result beat changed");

   // a miss reports zero id and sum
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_match_found |-> rsp_best_id == 20'd0 && rsp_best_sum == 24'd0)
      else $error("miss with nonzero id or sum");

   // a match needs at least one valid target pixel
   a_match_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_match_found |-> rsp_valid_count != 8'd0)
      else $error("match with zero valid count");

endmodule

bind masked_patch_sad_search mpss_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_match_found (rsp_match_found),
   .rsp_best_id     (rsp_best_id),
   .rsp_best_sum    (rsp_best_sum),
   .rsp_valid_count (rsp_valid_count)
);

// ===== dv/sad_match_checker.sv =====
// ============================================================================
// sad_match_checker
// Watches both channels of the masked patch SAD search block, keeps its own
// copy of the target patch and search state, predicts each search result and
// compares every returned result field by field, oldest prediction first.
// ============================================================================
module sad_match_checker #(
   parameter int PATCH_WINDOW   = 225,
   parameter int COLOR_CHANNELS = 3,
   parameter int INDEX_BITS     = 20
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           req_cmd,
   input  logic [mpss_pkg::POS_W-1:0]     req_position,
   input  logic [mpss_pkg::COLOR_W-1:0]   req_color_red,
   input  logic [mpss_pkg::COLOR_W-1:0]   req_color_green,
   input  logic [mpss_pkg::COLOR_W-1:0]   req_color_blue,
   input  logic [mpss_pkg::DEPTH_W-1:0]   req_depth_value,
   input  logic                           req_pixel_valid,
   input  logic [mpss_pkg::ID_W-1:0]      req_candidate_id,
   input  logic                           req_last_in_patch,
   input  logic                           req_last_candidate,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_match_found,
   input  logic [mpss_pkg::ID_W-1:0]      rsp_best_id,
   input  logic [mpss_pkg::SUM_W-1:0]     rsp_best_sum,
   input  logic [mpss_pkg::COUNT_W-1:0]   rsp_valid_count,
   output int                             fail_count,
   output int                             pending_count,
   output int                             result_count,
   output int                             empty_result_count
);
   import mpss_pkg::*;

   typedef struct {
      logic               match_found;
      logic [ID_W-1:0]    best_id;
      logic [SUM_W-1:0]   best_sum;
      logic [COUNT_W-1:0] valid_count;
   } search_result_type;

   search_result_type expected_matches[$];

   // target patch copy
   logic [COLOR_W-1:0] tp_color [PATCH_WINDOW][MAX_CHANNELS];
   logic [DEPTH_W-1:0] tp_depth [PATCH_WINDOW];
   logic               tp_known [PATCH_WINDOW];

   // search state
   logic [COUNT_W-1:0] counted_valid;
   logic [SUM_W-1:0]   patch_sum;
   logic [SUM_W-1:0]   lead_sum;
   logic [ID_W-1:0]    lead_id;
   logic               lead_held;

   search_result_type  got_result;

   function automatic int unsigned abs_gap(int unsigned a, int unsigned b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
         fail_count++;
      end
   endfunction

   // Advance the search state by one accepted pixel beat.
   task automatic predict_sad_beat();
      op_type             op;
      int unsigned        pos;
      int unsigned        diff;
      int                 nch;
      int                 c;
      logic [COLOR_W-1:0] col [MAX_CHANNELS];
      logic [SUM_W:0]     widened;
      logic [ID_W-1:0]    id_mask;
      search_result_type  res;

      op     = op_type'(req_cmd);
      pos    = req_position;
      col[0] = req_color_red;
      col[1] = req_color_green;
      col[2] = req_color_blue;
      nch    = (COLOR_CHANNELS > MAX_CHANNELS) ? MAX_CHANNELS : COLOR_CHANNELS;
      id_mask = '1;
      if (INDEX_BITS < ID_W) id_mask = id_mask >> (ID_W - INDEX_BITS);

      case (op)
         OP_LOAD: begin
            if (pos < PATCH_WINDOW) begin
               for (c = 0; c < MAX_CHANNELS; c++) tp_color[pos][c] = col[c];
               tp_depth[pos] = req_depth_value;
               tp_known[pos] = req_pixel_valid;
               if (pos == 0) begin
                  patch_sum     = '0;
                  lead_sum      = '0;
                  lead_id       = '0;
                  lead_held     = 1'b0;
                  counted_valid = COUNT_W'(req_pixel_valid);
               end else if (req_pixel_valid && counted_valid != COUNT_MAX) begin
                  counted_valid++;
               end
            end
         end
         OP_CAND: begin
            if (pos < PATCH_WINDOW && tp_known[pos]) begin
               diff = abs_gap(req_depth_value, tp_depth[pos]);
               for (c = 0; c < nch; c++) diff += abs_gap(col[c], tp_color[pos][c]);
               widened   = (SUM_W+1)'(patch_sum) + (SUM_W+1)'(diff);
               patch_sum = (widened > SUM_MAX) ? SUM_MAX : widened[SUM_W-1:0];
            end
            if (req_last_in_patch) begin
               // strictly smaller only: the earliest candidate keeps a tie
               if (counted_valid != 0 && (!lead_held || patch_sum < lead_sum)) begin
                  lead_sum  = patch_sum;
                  lead_id   = req_candidate_id & id_mask;
                  lead_held = 1'b1;
               end
               patch_sum = '0;
               if (req_last_candidate) begin
                  res.match_found = lead_held;
                  res.best_id     = lead_held ? lead_id : '0;
                  res.best_sum    = lead_held ? lead_sum : '0;
                  res.valid_count = counted_valid;
                  expected_matches.push_back(res);
                  lead_sum  = '0;
                  lead_id   = '0;
                  lead_held = 1'b0;
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fail_count         = 0;
         result_count       = 0;
         empty_result_count = 0;
         counted_valid      = '0;
         patch_sum          = '0;
         lead_sum           = '0;
         lead_id            = '0;
         lead_held          = 1'b0;
         expected_matches.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (!rsp_match_found) empty_result_count++;
            if (expected_matches.size() == 0) begin
               $display("%0t: result with no search pending, actual found=%0b id=0x%0h sum=0x%0h count=%0d",
                        $time, rsp_match_found, rsp_best_id, rsp_best_sum, rsp_valid_count);
               fail_count++;
            end else begin
               got_result = expected_matches.pop_front();
               check_field("match_found", 32'(got_result.match_found), 32'(rsp_match_found));
               check_field("best_id", 32'(got_result.best_id), 32'(rsp_best_id));
               check_field("best_sum", 32'(got_result.best_sum), 32'(rsp_best_sum));
               check_field("valid_count", 32'(got_result.valid_count), 32'(rsp_valid_count));
            end
         end
         if (req_valid && req_ready) predict_sad_beat();
      end
      pending_count = expected_matches.size();
   end

endmodule

// ===== dv/masked_patch_sad_search_test.sv =====
// ============================================================================
// masked_patch_sad_search_test
// Drives target loads and candidate patch streams into the SAD search block:
// a directed opening for ties, masking, out-of-window and empty searches,
// then random searches of mostly small windows plus one full-window search
// that saturates both the valid count and the sum. Both channels idle at
// random; the checker beside the block predicts and compares the results.
// ============================================================================
module masked_patch_sad_search_test;
   import mpss_pkg::*;

   localparam int PATCH_WINDOW   = 225;
   localparam int COLOR_CHANNELS = 3;
   localparam int INDEX_BITS     = 20;
   localparam int RESET_CYCLES   = 11;
   localparam int RANDOM_BEATS   = 1500;
   localparam int HOLD_CYCLES    = 300;
   localparam int STALL_LIMIT    = 2000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int LONG_BURST     = 300;

   typedef enum { RX_EAGER, RX_COIN, RX_SLUGGISH } rx_mode_type;
   typedef enum { PIX_EXACT, PIX_NEAR, PIX_RANDOM } pix_mode_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic          req_cmd = 1'b0;
   logic [7:0]    req_position = '0;
   logic [7:0]    req_color_red = '0;
   logic [7:0]    req_color_green = '0;
   logic [7:0]    req_color_blue = '0;
   logic [15:0]   req_depth_value = '0;
   logic          req_pixel_valid = 1'b0;
   logic [19:0]   req_candidate_id = '0;
   logic          req_last_in_patch = 1'b0;
   logic          req_last_candidate = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic          rsp_match_found;
   logic [19:0]   rsp_best_id;
   logic [23:0]   rsp_best_sum;
   logic [7:0]    rsp_valid_count;

   int            fail_count;
   int            pending_count;
   int            result_count;
   int            empty_result_count;

   // stimulus-side copy of the target, used to build close candidates
   logic [7:0]    gen_red   [PATCH_WINDOW];
   logic [7:0]    gen_green [PATCH_WINDOW];
   logic [7:0]    gen_blue  [PATCH_WINDOW];
   logic [15:0]   gen_depth [PATCH_WINDOW];

   int            cur_window = 0;
   int            beats_sent = 0;
   int            burst_left = 1;
   int            quiet_cycles = 0;
   bit            hold_wanted = 1'b0;
   bit            hold_done = 1'b0;
   bit            saturate_done = 1'b0;

   masked_patch_sad_search #(
      .PATCH_WINDOW   (PATCH_WINDOW),
      .COLOR_CHANNELS (COLOR_CHANNELS),
      .INDEX_BITS     (INDEX_BITS)
   ) DUT (.*);

   sad_match_checker #(
      .PATCH_WINDOW   (PATCH_WINDOW),
      .COLOR_CHANNELS (COLOR_CHANNELS),
      .INDEX_BITS     (INDEX_BITS)
   ) match_checker (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [7:0] rand_color();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] rand_depth();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Present one beat, hold it until accepted, then advance the burst pattern.
   task automatic send_beat(op_type op, int pos, logic [7:0] r, logic [7:0] g,
                            logic [7:0] b, logic [15:0] d, logic pv,
                            logic [19:0] cid, logic lip, logic lc);
      req_cmd            = op;
      req_position       = 8'(pos);
      req_color_red      = r;
      req_color_green    = g;
      req_color_blue     = b;
      req_depth_value    = d;
      req_pixel_valid    = pv;
      req_candidate_id   = cid;
      req_last_in_patch  = lip;
      req_last_candidate = lc;
      req_valid          = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
      if (op == OP_LOAD && pos < PATCH_WINDOW) begin
         gen_red[pos]   = r;
         gen_green[pos] = g;
         gen_blue[pos]  = b;
         gen_depth[pos] = d;
      end
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? LONG_BURST : $urandom_range(1, 40);
      end
   endtask

   task automatic load_target(int n);
      int p;
      for (p = 0; p < n; p++) begin
         send_beat(OP_LOAD, p, rand_color(), rand_color(), rand_color(), rand_depth(),
                   $urandom_range(0, 7) != 0, 20'($urandom), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
         // sprinkle ignored out-of-window loads and repeated positions
         if (p > 0 && $urandom_range(0, 9) == 0)
            send_beat(OP_LOAD, $urandom_range(0, 1) ? $urandom_range(PATCH_WINDOW, 255)
                                                    : $urandom_range(1, p),
                      rand_color(), rand_color(), rand_color(), rand_depth(),
                      1'($urandom_range(0, 1)), 20'($urandom), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
      end
      cur_window = n;
   endtask

   task automatic run_candidate(logic [19:0] cid, logic ends_search);
      pix_mode_type mode;
      int          count;
      int          i;
      int          pos;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic [15:0] d;
      logic        lip;
      mode  = pix_mode_type'($urandom_range(0, 2));
      count = ($urandom_range(0, 2) == 0) ? $urandom_range(1, cur_window + 2) : cur_window;
      for (i = 0; i < count; i++) begin
         pos = i % cur_window;
         if ($urandom_range(0, 5) == 0) pos = $urandom_range(0, cur_window - 1);
         if ($urandom_range(0, 19) == 0) pos = $urandom_range(PATCH_WINDOW, 255);
         if (mode == PIX_RANDOM || pos >= PATCH_WINDOW) begin
            r = rand_color();
            g = rand_color();
            b = rand_color();
            d = rand_depth();
         end else begin
            r = gen_red[pos];
            g = gen_green[pos];
            b = gen_blue[pos];
            d = gen_depth[pos];
            if (mode == PIX_NEAR) begin
               r = r ^ 8'($urandom_range(0, 3));
               d = d ^ 16'($urandom_range(1, 7));
            end
         end
         lip = (i == count - 1);
         send_beat(OP_CAND, pos, r, g, b, d, 1'($urandom_range(0, 1)), cid, lip,
                   lip ? ends_search : ($urandom_range(0, 7) == 0));
      end
   endtask

   task automatic run_search();
      int   k;
      int   c;
      logic aborted;
      if (cur_window == 0 || $urandom_range(0, 4) != 0)
         load_target(($urandom_range(0, 9) == 0) ? $urandom_range(16, 48)
                                                 : $urandom_range(1, 12));
      k       = $urandom_range(1, 5);
      aborted = ($urandom_range(0, 9) == 0);
      for (c = 0; c < k; c++) run_candidate(20'($urandom), (c == k - 1) && !aborted);
   endtask

   // Full window, over-counted valid pixels and a candidate long enough to
   // clip the sum at its maximum.
   task automatic saturate_search();
      int p;
      for (p = 0; p < PATCH_WINDOW; p++)
         send_beat(OP_LOAD, p, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, 20'($urandom), 1'b0, 1'b0);
      for (p = 1; p <= 40; p++)
         send_beat(OP_LOAD, p, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, 20'($urandom), 1'b0, 1'b0);
      for (p = 0; p < 260; p++)
         send_beat(OP_CAND, p % PATCH_WINDOW, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF,
                   1'($urandom_range(0, 1)), 20'hFFFFF, p == 259, p == 259);
      cur_window = 0;
   endtask

   // Result side: stall patterns in segments, plus one long hold-off.
   initial begin
      rx_mode_type mode;
      int       seg;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_wanted && !hold_done) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         mode = rx_mode_type'($urandom_range(0, 2));
         seg  = $urandom_range(20, 150);
         repeat (seg) begin
            case (mode)
               RX_EAGER: rsp_ready = 1'b1;
               RX_COIN:  rsp_ready = 1'($urandom_range(0, 1));
               default:  rsp_ready = ($urandom_range(0, 3) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_count);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      burst_left = $urandom_range(1, 40);

      // directed opening
      send_beat(OP_LOAD, 0, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, 20'h00000, 1'b0, 1'b0);
      send_beat(OP_LOAD, 1, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, 20'hFFFFF, 1'b1, 1'b1);
      send_beat(OP_LOAD, 2, 8'h33, 8'hCC, 8'h3C, 16'h1234, 1'b0, 20'h55555, 1'b0, 1'b0);
      send_beat(OP_LOAD, 224, 8'h5A, 8'hA5, 8'h0F, 16'hF00F, 1'b1, 20'hAAAAA, 1'b0, 1'b1);
      // out of window: dropped
      send_beat(OP_LOAD, 240, 8'h11, 8'h22, 8'h33, 16'h4444, 1'b1, 20'h00001, 1'b1, 1'b0);
      // same position again counts twice
      send_beat(OP_LOAD, 1, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, 20'h00000, 1'b0, 1'b0);
      // first candidate: one maximal difference, a stray last_candidate, a masked pixel
      send_beat(OP_CAND, 0, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b0, 20'hFFFFF, 1'b0, 1'b1);
      send_beat(OP_CAND, 2, 8'h00, 8'hFF, 8'h00, 16'hFFFF, 1'b1, 20'hFFFFF, 1'b0, 1'b0);
      send_beat(OP_CAND, 250, 8'hFF, 8'h00, 8'hFF, 16'h0000, 1'b1, 20'hFFFFF, 1'b1, 1'b0);
      // second candidate ties the first, which must stay best
      send_beat(OP_CAND, 1, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 20'h00001, 1'b0, 1'b0);
      send_beat(OP_CAND, 224, 8'h5A, 8'hA5, 8'h0F, 16'hF00F, 1'b0, 20'h00001, 1'b1, 1'b0);
      // exact match wins and closes the search
      send_beat(OP_CAND, 224, 8'h5A, 8'hA5, 8'h0F, 16'hF00F, 1'b1, 20'h12345, 1'b1, 1'b1);
      // a further search on the kept target
      send_beat(OP_CAND, 250, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 20'hABCDE, 1'b1, 1'b1);
      // restart with no valid pixel: no match possible
      send_beat(OP_LOAD, 0, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b0, 20'hFFFFF, 1'b1, 1'b1);
      send_beat(OP_CAND, 1, 8'h00, 8'h00, 8'h00, 16'h0000, 1'b1, 20'h00007, 1'b1, 1'b1);
      send_beat(OP_CAND, 250, 8'h80, 8'h01, 8'h7F, 16'h8001, 1'b0, 20'h80000, 1'b0, 1'b1);
      send_beat(OP_CAND, 255, 8'h01, 8'h80, 8'hFE, 16'h7FFE, 1'b1, 20'h7FFFF, 1'b1, 1'b1);

      // random searches; the receiver holds off once early on
      cur_window  = 0;
      hold_wanted = 1'b1;
      while (beats_sent < RANDOM_BEATS) begin
         if (!saturate_done && beats_sent > 500) begin
            saturate_search();
            saturate_done = 1'b1;
         end else begin
            run_search();
         end
      end
      req_valid = 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Run covered %0d pixel beats and %0d search results (%0d without a match),",
               beats_sent, result_count, empty_result_count);
      $display("including ties, masked and out-of-window pixels, and a saturating full window.");
      if (fail_count == 0 && pending_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
